// ----- rtl/core/rsxb_pkg.sv -----
// ----------------------------------------------------------------------------
// Image checksum package
// Shared types and constants for the image sum, XOR and balance-word checker.
// ----------------------------------------------------------------------------
package rsxb_pkg;

   localparam int CSR_INDEX_BITS = 2;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHECK_BYTE_ADDRESS = 2'd0,
      CSR_BALANCE_ADDRESS    = 2'd1,
      CSR_WORD_REGION_START  = 2'd2,
      CSR_TARGET_WORD_SUM    = 2'd3
   } csr_index_type;

   localparam logic [15:0] TARGET_WORD_SUM_RESET = 16'h5aa5;

   // One result of an image.
   typedef struct packed {
      logic [7:0]  sum_byte;
      logic [7:0]  xor_byte;
      logic [15:0] balance_word;
      logic        sum_fix;
      logic        xor_fix;
      logic        balance_fix;
      logic        outcome;
   } result_type;

endpackage

// ----- rtl/core/rsxb_if.sv -----
// ----------------------------------------------------------------------------
// Image checksum channels
// Valid/ready channels for image bytes, results and register writes.
// ----------------------------------------------------------------------------
interface rsxb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rom_byte;
   logic       last_byte;

   modport source (output valid, output rom_byte, output last_byte, input ready);
   modport sink (input valid, input rom_byte, input last_byte, output ready);
endinterface

interface rsxb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  sum_byte;
   logic [7:0]  xor_byte;
   logic [15:0] balance_word;
   logic        sum_fix;
   logic        xor_fix;
   logic        balance_fix;
   logic        outcome;

   modport source (output valid, output sum_byte, output xor_byte, output balance_word,
                   output sum_fix, output xor_fix, output balance_fix, output outcome,
                   input ready);
   modport sink (input valid, input sum_byte, input xor_byte, input balance_word,
                 input sum_fix, input xor_fix, input balance_fix, input outcome,
                 output ready);
endinterface

interface rsxb_csr_if #(
   parameter int DATA_BITS = 19
);
   logic                                valid;
   logic                                ready;
   logic [rsxb_pkg::CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rsxb_accum.sv -----
// ----------------------------------------------------------------------------
// Image checksum accumulator
// Per-image state: byte address, sum, XOR, word sum and captured check values.
// ----------------------------------------------------------------------------
module rsxb_accum #(
   parameter int ADDRESS_BITS = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rom_byte,
   input  logic                    last_byte,
   input  logic [ADDRESS_BITS-1:0] check_byte_address,
   input  logic [ADDRESS_BITS-1:0] balance_address,
   input  logic [ADDRESS_BITS-1:0] word_region_start,
   input  logic [15:0]             target_word_sum,
   output rsxb_pkg::result_type    result
);
   import rsxb_pkg::*;

   localparam int AW = ADDRESS_BITS + 1;

   logic [AW-1:0] byte_address_ff, byte_address_in;
   logic [7:0]    running_sum_ff, running_sum_in;
   logic [7:0]    running_xor_ff, running_xor_in;
   logic [15:0]   word_sum_ff, word_sum_in;
   logic [7:0]    pending_high_ff, pending_high_in;
   logic [7:0]    stored_sum_ff, stored_sum_in;
   logic [7:0]    stored_xor_ff, stored_xor_in;
   logic [15:0]   stored_balance_ff, stored_balance_in;

   logic [AW-1:0] chk_addr, chk_addr_next, bal_addr, bal_addr_next, region_addr;
   logic          in_space, hit_sum, hit_xor, word_counts;
   logic [15:0]   word_total, diff;
   logic          bfix, sfix, xfix;

   always_comb begin
      chk_addr      = {1'b0, check_byte_address};
      chk_addr_next = chk_addr + AW'(1);
      bal_addr      = {1'b0, balance_address};
      bal_addr_next = bal_addr + AW'(1);
      region_addr   = {1'b0, word_region_start[ADDRESS_BITS-1:2], 2'b00};

      // The top bit marks an address counter that has run past the space.
      in_space = !byte_address_ff[ADDRESS_BITS];
      hit_sum  = in_space && (byte_address_ff == chk_addr);
      hit_xor  = in_space && (byte_address_ff == chk_addr_next);

      running_sum_in = running_sum_ff;
      running_xor_in = running_xor_ff;
      if (!(hit_sum || hit_xor)) begin
         running_sum_in = running_sum_ff + rom_byte;
         running_xor_in = running_xor_ff ^ rom_byte;
      end

      stored_sum_in = hit_sum ? rom_byte : stored_sum_ff;
      stored_xor_in = hit_xor ? rom_byte : stored_xor_ff;
      stored_balance_in = stored_balance_ff;
      if (in_space && byte_address_ff == bal_addr) begin
         stored_balance_in[15:8] = rom_byte;
      end
      if (in_space && byte_address_ff == bal_addr_next) begin
         stored_balance_in[7:0] = rom_byte;
      end

      // The word that holds the sum byte is left out of the word sum.
      word_counts = in_space && (byte_address_ff >= region_addr)
                    && (byte_address_ff[AW-1:2] != chk_addr[AW-1:2]);

      word_total      = word_sum_ff;
      word_sum_in     = word_sum_ff;
      pending_high_in = pending_high_ff;
      if (word_counts) begin
         case (byte_address_ff[1:0])
            2'd2: begin
               pending_high_in = rom_byte;
               // An image that ends mid-word counts the missing low byte as zero.
               if (last_byte) begin
                  word_total = word_sum_ff + {rom_byte, 8'h00};
               end
            end
            2'd3: begin
               word_total  = word_sum_ff + {pending_high_ff, rom_byte};
               word_sum_in = word_total;
            end
            default: begin
               word_total = word_sum_ff;
            end
         endcase
      end

      byte_address_in = in_space ? byte_address_ff + AW'(1) : byte_address_ff;

      diff = target_word_sum - word_total;
      bfix = (word_total != target_word_sum);
      sfix = (running_sum_in != stored_sum_in);
      xfix = (running_xor_in != stored_xor_in);

      result.sum_byte     = running_sum_in;
      result.xor_byte     = running_xor_in;
      result.balance_word = bfix ? stored_balance_in + diff : stored_balance_in;
      result.sum_fix      = sfix;
      result.xor_fix      = xfix;
      result.balance_fix  = bfix;
      result.outcome      = sfix || xfix || bfix;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last_byte)) begin
         byte_address_ff   <= '0;
         running_sum_ff    <= '0;
         running_xor_ff    <= '0;
         word_sum_ff       <= '0;
         pending_high_ff   <= '0;
         stored_sum_ff     <= '0;
         stored_xor_ff     <= '0;
         stored_balance_ff <= '0;
      end else if (step_en) begin
         byte_address_ff   <= byte_address_in;
         running_sum_ff    <= running_sum_in;
         running_xor_ff    <= running_xor_in;
         word_sum_ff       <= word_sum_in;
         pending_high_ff   <= pending_high_in;
         stored_sum_ff     <= stored_sum_in;
         stored_xor_ff     <= stored_xor_in;
         stored_balance_ff <= stored_balance_in;
      end
   end

endmodule

// ----- rtl/core/rom_sum_xor_balance_checksum.sv -----
// ----------------------------------------------------------------------------
// Image sum, XOR and balance-word checker
// Streams an image byte by byte and reports its check bytes and balance word.
// ----------------------------------------------------------------------------
// The last byte of an image passes through the input register and then loads
// the result register, which raises rsp valid.
// Throughput: one request per cycle, back to back; a byte needs only an add, an
// XOR and a capture. Only a last byte can wait, holding up the requests behind
// it, and only while the previous result is still held on rsp.
// Reset (synchronous, active high) restores register defaults and clears state.
module rom_sum_xor_balance_checksum #(
   parameter int ADDRESS_BITS               = 19,
   parameter int CHECK_BYTE_ADDRESS_RESET   = 'h08100,
   parameter int BALANCE_ADDRESS_RESET      = 'h7fffa,
   parameter int WORD_REGION_START_RESET    = 'h04000
) (
   input logic        clock,
   input logic        reset,
   rsxb_req_if.sink   req_ch,
   rsxb_rsp_if.source rsp_ch,
   rsxb_csr_if.sink   csr_ch
);
   import rsxb_pkg::*;

   // Configuration registers. Writes are always taken; the user must send writes
   // only while the block is idle, which the block itself does not enforce.
   logic [ADDRESS_BITS-1:0] check_byte_address_ff;
   logic [ADDRESS_BITS-1:0] balance_address_ff;
   logic [ADDRESS_BITS-1:0] word_region_start_ff;
   logic [15:0]             target_word_sum_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_byte_address_ff <= ADDRESS_BITS'(CHECK_BYTE_ADDRESS_RESET);
         balance_address_ff    <= ADDRESS_BITS'(BALANCE_ADDRESS_RESET);
         word_region_start_ff  <= ADDRESS_BITS'(WORD_REGION_START_RESET);
         target_word_sum_ff    <= TARGET_WORD_SUM_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_CHECK_BYTE_ADDRESS: check_byte_address_ff <= csr_ch.data[ADDRESS_BITS-1:0];
            CSR_BALANCE_ADDRESS:    balance_address_ff    <= csr_ch.data[ADDRESS_BITS-1:0];
            CSR_WORD_REGION_START:  word_region_start_ff  <= csr_ch.data[ADDRESS_BITS-1:0];
            CSR_TARGET_WORD_SUM:    target_word_sum_ff    <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Input register. A byte that is not the last one never needs the
   // result register, so it moves on even while a result waits.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_free;
   logic       step_en;
   logic       req_take;

   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type step_result;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step_en      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ch.ready = !in_valid_ff || step_en;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_take) begin
         in_byte_ff <= req_ch.rom_byte;
         in_last_ff <= req_ch.last_byte;
      end
   end

   rsxb_accum #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_accum (
      .clock              (clock),
      .reset              (reset),
      .step_en            (step_en),
      .rom_byte           (in_byte_ff),
      .last_byte          (in_last_ff),
      .check_byte_address (check_byte_address_ff),
      .balance_address    (balance_address_ff),
      .word_region_start  (word_region_start_ff),
      .target_word_sum    (target_word_sum_ff),
      .result             (step_result)
   );

   // Result register: loaded by the last byte of an image, held until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_en && in_last_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sum_byte     = rsp_data_ff.sum_byte;
   assign rsp_ch.xor_byte     = rsp_data_ff.xor_byte;
   assign rsp_ch.balance_word = rsp_data_ff.balance_word;
   assign rsp_ch.sum_fix      = rsp_data_ff.sum_fix;
   assign rsp_ch.xor_fix      = rsp_data_ff.xor_fix;
   assign rsp_ch.balance_fix  = rsp_data_ff.balance_fix;
   assign rsp_ch.outcome      = rsp_data_ff.outcome;

endmodule

// ----- tb/rom_sum_xor_balance_checksum_test.sv -----
// ----------------------------------------------------------------------------
// Image checksum checker testbench
// Streams firmware images through the checker under changing register
// layouts, predicts each image's sum byte, XOR byte, balance word and fix
// flags with a behavioral model of its own, and compares every result.
// ----------------------------------------------------------------------------
module rom_sum_xor_balance_checksum_test;
   import rsxb_pkg::*;

   // Register defaults of the block (its parameters are left at their defaults).
   localparam logic [18:0] CHECK_ADDRESS_DEFAULT   = 19'h08100;
   localparam logic [18:0] BALANCE_ADDRESS_DEFAULT = 19'h7fffa;
   localparam logic [18:0] REGION_START_DEFAULT    = 19'h04000;

   // Highest legal values of the address registers.
   localparam int unsigned ADDRESS_MAX = 524286;
   localparam int unsigned REGION_MAX  = 524284;

   // The byte counter stops at the top of the 19-bit address space.
   localparam logic [19:0] ADDRESS_SPACE = 20'h80000;

   // Number of image bytes the random part aims for.
   localparam int unsigned RANDOM_BYTES = 1800;

   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned HANG_LIMIT = 1000;

   // Margin waited once all results are back, so that the block is idle.
   localparam int unsigned SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset;

   rsxb_req_if req_ch ();
   rsxb_rsp_if rsp_ch ();
   rsxb_csr_if csr_ch ();

   rom_sum_xor_balance_checksum uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state. The register copies follow every accepted register
   // write; the image state follows every accepted request.
   // ------------------------------------------------------------------------
   logic [18:0] cfg_check_addr   = CHECK_ADDRESS_DEFAULT;
   logic [18:0] cfg_balance_addr = BALANCE_ADDRESS_DEFAULT;
   logic [18:0] cfg_region_start = REGION_START_DEFAULT;
   logic [15:0] cfg_target       = TARGET_WORD_SUM_RESET;

   logic [19:0] image_addr       = '0;
   logic [7:0]  byte_sum         = '0;
   logic [7:0]  byte_xor         = '0;
   logic [15:0] low_half_sum     = '0;
   logic [7:0]  held_high        = '0;
   logic [7:0]  captured_sum     = '0;
   logic [7:0]  captured_xor     = '0;
   logic [15:0] captured_balance = '0;

   // Checksums predicted for images whose last byte has been accepted.
   result_type pending_checksums[$];

   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned random_bytes_sent = 0;

   // Idling switches, changed between phases by the stimulus.
   bit idle_requests = 1'b1;
   bit stall_results = 1'b1;

   // Scratch image built by the stimulus tasks before it is streamed.
   logic [7:0] image_bytes[$];

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("mismatch in %s at %0t: got %h, wanted %h", what, $time, got, want);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(0, 3);
      return $urandom_range(4, 40);
   endfunction

   // Folds one accepted image byte into the predicted state. On the last byte
   // it queues the checksums that the block must report and starts afresh.
   function automatic void fold_image_byte(input logic [7:0] value, input logic is_last);
      logic [19:0] addr;
      logic        in_space;
      logic [15:0] words;
      logic [19:0] sum_at;
      logic [19:0] xor_at;
      logic [19:0] bal_at;
      logic [19:0] region;
      result_type  outcome_now;

      addr     = image_addr;
      in_space = addr < ADDRESS_SPACE;
      words    = low_half_sum;
      sum_at   = {1'b0, cfg_check_addr};
      xor_at   = sum_at + 20'd1;
      bal_at   = {1'b0, cfg_balance_addr};
      region   = {1'b0, cfg_region_start[18:2], 2'b00};

      // The two check bytes stay out of the byte sum and XOR, but only while
      // the address still means something.
      if (!(in_space && (addr == sum_at || addr == xor_at))) begin
         byte_sum = byte_sum + value;
         byte_xor = byte_xor ^ value;
      end

      if (in_space) begin
         if (addr == sum_at)
            captured_sum = value;
         if (addr == xor_at)
            captured_xor = value;
         if (addr == bal_at)
            captured_balance[15:8] = value;
         if (addr == bal_at + 20'd1)
            captured_balance[7:0] = value;

         // Only the low half of each big-endian word counts, and the word
         // holding the stored sum byte is skipped entirely.
         if (addr >= region && addr[19:2] != sum_at[19:2]) begin
            if (addr[1:0] == 2'd2) begin
               held_high = value;
               // An image cut short after the high byte counts it alone.
               if (is_last)
                  words = words + {value, 8'h00};
            end else if (addr[1:0] == 2'd3) begin
               words = words + {held_high, value};
               low_half_sum = words;
            end
         end
         image_addr = addr + 20'd1;
      end

      if (is_last) begin
         outcome_now.sum_byte     = byte_sum;
         outcome_now.xor_byte     = byte_xor;
         outcome_now.sum_fix      = byte_sum != captured_sum;
         outcome_now.xor_fix      = byte_xor != captured_xor;
         outcome_now.balance_fix  = words != cfg_target;
         outcome_now.balance_word = captured_balance;
         if (outcome_now.balance_fix)
            outcome_now.balance_word = captured_balance + (cfg_target - words);
         outcome_now.outcome = outcome_now.sum_fix | outcome_now.xor_fix |
                               outcome_now.balance_fix;
         pending_checksums.insert(pending_checksums.size(), outcome_now);

         image_addr       = '0;
         byte_sum         = '0;
         byte_xor         = '0;
         low_half_sum     = '0;
         held_high        = '0;
         captured_sum     = '0;
         captured_xor     = '0;
         captured_balance = '0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitors. They sample at the rising edge, where the handshake signals
   // still hold the values that decided the transfer.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         fold_image_byte(req_ch.rom_byte, req_ch.last_byte);
   end

   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_CHECK_BYTE_ADDRESS: cfg_check_addr = csr_ch.data;
            CSR_BALANCE_ADDRESS:    cfg_balance_addr = csr_ch.data;
            CSR_WORD_REGION_START:  cfg_region_start = csr_ch.data;
            CSR_TARGET_WORD_SUM:    cfg_target = csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   // Every accepted result must match the oldest prediction field by field.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_checksums.size() == 0) begin
            report_mismatch("result with no image pending", 0, 0);
         end else begin
            want = pending_checksums.pop_front();
            if (rsp_ch.sum_byte !== want.sum_byte)
               report_mismatch("sum_byte", rsp_ch.sum_byte, want.sum_byte);
            if (rsp_ch.xor_byte !== want.xor_byte)
               report_mismatch("xor_byte", rsp_ch.xor_byte, want.xor_byte);
            if (rsp_ch.balance_word !== want.balance_word)
               report_mismatch("balance_word", rsp_ch.balance_word, want.balance_word);
            if (rsp_ch.sum_fix !== want.sum_fix)
               report_mismatch("sum_fix", rsp_ch.sum_fix, want.sum_fix);
            if (rsp_ch.xor_fix !== want.xor_fix)
               report_mismatch("xor_fix", rsp_ch.xor_fix, want.xor_fix);
            if (rsp_ch.balance_fix !== want.balance_fix)
               report_mismatch("balance_fix", rsp_ch.balance_fix, want.balance_fix);
            if (rsp_ch.outcome !== want.outcome)
               report_mismatch("outcome", rsp_ch.outcome, want.outcome);
         end
      end
   end

   // The watchdog restarts on any handshake on any channel. Gaps and stalls
   // stay well below the limit, so only a real hang can reach it.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result-side back-pressure: runs of ready followed, when stalls are on,
   // by a gap. The first edge is waited for so that ready gets only one
   // assignment at time zero.
   initial begin : pace_results
      int unsigned span;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         span = $urandom_range(1, 30);
         repeat (span) @(posedge clock);
         if (stall_results) begin
            span = gap_length();
            if (span != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers.
   // ------------------------------------------------------------------------

   // Offers one image byte and returns at the edge that accepts it. Valid is
   // left high so that requests can follow back to back.
   task automatic send_request(input logic [7:0] value, input logic is_last);
      int unsigned gap;
      if (idle_requests) begin
         gap = gap_length();
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.rom_byte  <= value;
      req_ch.last_byte <= is_last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_image();
      int unsigned i;
      for (i = 0; i < image_bytes.size(); i++)
         send_request(image_bytes[i], i == image_bytes.size() - 1);
      random_bytes_sent += image_bytes.size();
   endtask

   // Drops valid, waits for every predicted result, then lets the block
   // settle so that the next register write lands while it is idle. The
   // first edge lets the monitor fold the request accepted last.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_checksums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [18:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Writes all four registers; only called with the block idle.
   task automatic apply_layout(input logic [18:0] check_addr, input logic [18:0] balance_addr,
                               input logic [18:0] region_start, input logic [15:0] target);
      write_register(CSR_CHECK_BYTE_ADDRESS, check_addr);
      write_register(CSR_BALANCE_ADDRESS, balance_addr);
      write_register(CSR_WORD_REGION_START, region_start);
      write_register(CSR_TARGET_WORD_SUM, {3'b000, target});
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Builds an image that already carries correct check bytes and a balance
   // word that brings the word sum onto the target. It relies on the layout
   // chosen by the random test: the sum and XOR bytes share one word, the
   // balance word is the low half of a word inside the region, and the image
   // ends on a word boundary past both.
   function automatic void build_balanced_image(input int unsigned words);
      int unsigned sum_at;
      int unsigned bal_at;
      int unsigned region;
      int unsigned i;
      logic [15:0] others;
      logic [15:0] balance_value;
      logic [7:0]  total;
      logic [7:0]  parity;

      sum_at = 32'(cfg_check_addr);
      bal_at = 32'(cfg_balance_addr);
      region = 32'({cfg_region_start[18:2], 2'b00});
      image_bytes.delete();
      for (i = 0; i < words * 4; i++)
         image_bytes.insert(image_bytes.size(), 8'($urandom));

      others = '0;
      for (i = region; i < words * 4; i += 4) begin
         if (i / 4 != sum_at / 4 && i != bal_at - 2)
            others += {image_bytes[i + 2], image_bytes[i + 3]};
      end
      balance_value           = cfg_target - others;
      image_bytes[bal_at]     = balance_value[15:8];
      image_bytes[bal_at + 1] = balance_value[7:0];

      // The check bytes are filled in last, since the balance word feeds them.
      total  = '0;
      parity = '0;
      for (i = 0; i < words * 4; i++) begin
         if (i != sum_at && i != sum_at + 1) begin
            total  += image_bytes[i];
            parity ^= image_bytes[i];
         end
      end
      image_bytes[sum_at]     = total;
      image_bytes[sum_at + 1] = parity;
   endfunction

   // Arbitrary bytes of arbitrary length, mostly short.
   function automatic void build_noise_image();
      int unsigned length;
      length = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 300)
                                            : $urandom_range(1, 64);
      image_bytes.delete();
      repeat (length) image_bytes.insert(image_bytes.size(), 8'($urandom));
   endfunction

   // Low extreme, high extreme or anything in between.
   function automatic logic [18:0] pick_register(input int unsigned highest);
      case ($urandom_range(0, 2))
         0: return '0;
         1: return 19'(highest);
         default: return 19'($urandom_range(0, highest));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Out of reset the check bytes and the region lie far beyond a short
   // image: nothing is captured, so the stored values read as zero and the
   // balance word becomes the plain target.
   task automatic test_register_defaults();
      image_bytes = '{8'h00, 8'hff, 8'h80, 8'h01};
      send_image();
      image_bytes = '{8'hff};
      send_image();
      wait_for_results();
   endtask

   // All registers at their low extremes: the sum byte and the balance high
   // byte share address zero, word zero is skipped, the target is zero.
   // Then the high extremes, where nothing of a short image is captured.
   task automatic test_register_extremes();
      apply_layout('0, '0, '0, 16'h0000);
      image_bytes = '{8'ha5, 8'h5a, 8'h12, 8'h34, 8'hff, 8'h00, 8'hff, 8'h00, 8'h7e};
      send_image();
      wait_for_results();
      apply_layout(19'(ADDRESS_MAX), 19'(ADDRESS_MAX), 19'(REGION_MAX), 16'hffff);
      image_bytes = '{8'h80, 8'h7f};
      send_image();
      wait_for_results();
   endtask

   // An unaligned region start (its low bits are dropped), a sum byte in the
   // last slot of its word so the XOR byte lands in a word that does count,
   // and an image that stops right after a high byte.
   task automatic test_unaligned_layout();
      apply_layout(19'd7, 19'd12, 19'd5, 16'h1234);
      image_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                      8'h99, 8'haa, 8'hbb};
      send_image();
      wait_for_results();
   endtask

   // Phases of random layouts. Most use a compact layout near address zero,
   // where images are mostly well formed (correct or with one flipped bit)
   // so that the unchanged outcome is reached; the rest are noise. Some
   // phases use wide layouts from the full register ranges.
   task automatic test_random_images();
      bit          compact;
      int unsigned region_word;
      int unsigned check_word;
      int unsigned check_slot;
      int unsigned balance_word_index;
      int unsigned words;
      int unsigned kind;
      int unsigned spot;

      random_bytes_sent = 0;
      while (random_bytes_sent < RANDOM_BYTES) begin
         idle_requests = $urandom_range(0, 9) < 7;
         stall_results = $urandom_range(0, 9) < 7;
         compact       = $urandom_range(0, 3) != 0;
         region_word        = $urandom_range(0, 3);
         check_word         = $urandom_range(0, 10);
         check_slot         = $urandom_range(0, 3);
         balance_word_index = check_word;
         while (balance_word_index == check_word)
            balance_word_index = $urandom_range(region_word, 11);

         if (compact)
            apply_layout(19'(check_word * 4 + check_slot), 19'(balance_word_index * 4 + 2),
                         19'(region_word * 4 + $urandom_range(0, 3)), 16'($urandom));
         else
            apply_layout(pick_register(ADDRESS_MAX), pick_register(ADDRESS_MAX),
                         pick_register(REGION_MAX), 16'(pick_register(16'hffff)));

         repeat ($urandom_range(3, 8)) begin
            kind = $urandom_range(0, 9);
            if (compact && check_slot != 3 && kind < 8) begin
               words = ((check_word > balance_word_index) ? check_word : balance_word_index)
                       + 1 + $urandom_range(0, 4);
               build_balanced_image(words);
               // A single flipped bit anywhere breaks at least one check.
               if (kind >= 6) begin
                  spot = $urandom_range(0, image_bytes.size() - 1);
                  image_bytes[spot][$urandom_range(0, 7)] ^= 1'b1;
               end
            end else begin
               build_noise_image();
            end
            send_image();
         end
         wait_for_results();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence. Reset is held once, at the start.
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.rom_byte  <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_CHECK_BYTE_ADDRESS;
      csr_ch.data      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_register_extremes();
      test_unaligned_layout();
      test_random_images();

      // Every predicted result must have come back.
      if (pending_checksums.size() != 0)
         report_mismatch("results never returned", 0, pending_checksums.size());

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rsxb_pkg.sv
rtl/core/rsxb_if.sv
rtl/core/rsxb_accum.sv
rtl/core/rom_sum_xor_balance_checksum.sv
tb/rom_sum_xor_balance_checksum_test.sv
